@@ hw/rtl/rsbl_pkg.sv @@
// Shared types and constants for the red spot bounding-box locator.
// Depends on nothing; every other file of the block uses it by scoped names.
`default_nettype none

package rsbl_pkg;

   // Largest frame dimension; coordinates saturate to MAX_DIM-1
   localparam int MAX_DIM = 4096;

   localparam int CHAN_W     = 8;
   localparam int COORD_W    = 12;
   localparam int DIM_W      = 13;
   localparam int SCALE_W    = 20;
   localparam int SCALE_FRAC = 16;
   localparam int EXTENT_W   = 12;
   localparam int MARGIN_W   = 11;
   localparam int PROD_W     = DIM_W + SCALE_W - SCALE_FRAC;
   localparam int CLAMP_W    = PROD_W + 1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(MAX_DIM - 1);

   // Reset values
   localparam logic [DIM_W-1:0]    FRAME_WIDTH_RST    = 13'd640;
   localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RST   = 13'd480;
   localparam logic [SCALE_W-1:0]  SCALE_RST          = 20'd65536;
   localparam logic [EXTENT_W-1:0] PLATE_EXTENT_RST   = 12'd400;
   localparam logic [MARGIN_W-1:0] EDGE_MARGIN_RST    = 11'd20;
   localparam logic [CHAN_W-1:0]   DIFF_THRESHOLD_RST = 8'd80;
   localparam logic [CHAN_W-1:0]   CHANNEL_LIMIT_RST  = 8'd100;
   localparam logic [COORD_W-1:0]  HELD_RST           = 12'd200;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FRAME_WIDTH    = 3'd0,
      REG_FRAME_HEIGHT   = 3'd1,
      REG_SCALE_X        = 3'd2,
      REG_SCALE_Y        = 3'd3,
      REG_PLATE_EXTENT   = 3'd4,
      REG_EDGE_MARGIN    = 3'd5,
      REG_DIFF_THRESHOLD = 3'd6,
      REG_CHANNEL_LIMIT  = 3'd7
   } reg_index_type;

   // Input word: one pixel
   typedef struct packed {
      logic [CHAN_W-1:0]  pixel_blue;
      logic [CHAN_W-1:0]  pixel_green;
      logic [CHAN_W-1:0]  pixel_red;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               frame_last;
   } pixel_type;

   // Result word: spot position
   typedef struct packed {
      logic [COORD_W-1:0] spot_x;
      logic [COORD_W-1:0] spot_y;
      logic               spot_found;
   } spot_type;

   typedef struct packed {
      logic [DIM_W-1:0]    frame_width;
      logic [DIM_W-1:0]    frame_height;
      logic [SCALE_W-1:0]  scale_x;
      logic [SCALE_W-1:0]  scale_y;
      logic [EXTENT_W-1:0] plate_extent;
      logic [MARGIN_W-1:0] edge_margin;
      logic [CHAN_W-1:0]   diff_threshold;
      logic [CHAN_W-1:0]   channel_limit;
   } cfg_type;

   // Box start reload on a frame size write
   typedef struct packed {
      logic             load_x;
      logic             load_y;
      logic [DIM_W-1:0] value;
   } box_load_type;

   // Box centre of a finished frame
   typedef struct packed {
      logic [DIM_W-1:0] centre_x;
      logic [DIM_W-1:0] centre_y;
      logic             found;
   } centre_type;

   // Scaled centre before the clamp
   typedef struct packed {
      logic [PROD_W-1:0] scaled_x;
      logic [PROD_W-1:0] scaled_y;
      logic              found;
   } scaled_type;

endpackage

`default_nettype wire

@@ hw/rtl/rsbl_box.sv @@
// Pixel register, red test, bounding-box tracking and box centre register.
// Depends on rsbl_pkg.
`default_nettype none

module rsbl_box (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rsbl_pkg::cfg_type      cfg,
   input  wire rsbl_pkg::box_load_type box_load,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire rsbl_pkg::pixel_type    in_data,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output rsbl_pkg::centre_type        out_data
);

   logic                pix_valid_ff, pix_valid_in;
   rsbl_pkg::pixel_type pix_ff, pix_in;
   logic                 ctr_valid_ff, ctr_valid_in;
   rsbl_pkg::centre_type ctr_ff, ctr_in;

   logic [rsbl_pkg::DIM_W-1:0]   box_min_x_ff, box_min_x_in;
   logic [rsbl_pkg::DIM_W-1:0]   box_min_y_ff, box_min_y_in;
   logic [rsbl_pkg::COORD_W-1:0] box_max_x_ff, box_max_x_in;
   logic [rsbl_pkg::COORD_W-1:0] box_max_y_ff, box_max_y_in;

   logic [rsbl_pkg::COORD_W-1:0] col_c, row_c;
   logic [rsbl_pkg::CHAN_W:0]    blue_bar, green_bar, red_w;
   logic                         is_red;
   logic [rsbl_pkg::DIM_W-1:0]   min_x_nx, min_y_nx;
   logic [rsbl_pkg::COORD_W-1:0] max_x_nx, max_y_nx;
   logic [rsbl_pkg::DIM_W:0]     sum_x, sum_y;
   logic                         ctr_free, pix_leave;

   // Handshake: a non-final pixel always drains, a final one needs the centre stage
   assign ctr_free  = !ctr_valid_ff || out_ready;
   assign pix_leave = pix_valid_ff && (!pix_ff.frame_last || ctr_free);
   assign in_ready  = !pix_valid_ff || pix_leave;

   // Saturate coordinates and classify the pixel
   always_comb begin
      col_c = (pix_ff.column > rsbl_pkg::COORD_MAX) ? rsbl_pkg::COORD_MAX : pix_ff.column;
      row_c = (pix_ff.row > rsbl_pkg::COORD_MAX) ? rsbl_pkg::COORD_MAX : pix_ff.row;
      red_w     = {1'b0, pix_ff.pixel_red};
      blue_bar  = {1'b0, pix_ff.pixel_blue} + {1'b0, cfg.diff_threshold};
      green_bar = {1'b0, pix_ff.pixel_green} + {1'b0, cfg.diff_threshold};
      is_red = (red_w > blue_bar) && (red_w > green_bar) &&
               (pix_ff.pixel_green < cfg.channel_limit) &&
               (pix_ff.pixel_blue < cfg.channel_limit);
   end

   // Widen the box by a red pixel
   always_comb begin
      min_x_nx = box_min_x_ff;
      min_y_nx = box_min_y_ff;
      max_x_nx = box_max_x_ff;
      max_y_nx = box_max_y_ff;
      if (is_red) begin
         if (rsbl_pkg::DIM_W'(row_c) < box_min_y_ff) min_y_nx = rsbl_pkg::DIM_W'(row_c);
         if (rsbl_pkg::DIM_W'(col_c) < box_min_x_ff) min_x_nx = rsbl_pkg::DIM_W'(col_c);
         if (row_c > box_max_y_ff) max_y_nx = row_c;
         if (col_c > box_max_x_ff) max_x_nx = col_c;
      end
      sum_x = (rsbl_pkg::DIM_W + 1)'(min_x_nx) + (rsbl_pkg::DIM_W + 1)'(max_x_nx);
      sum_y = (rsbl_pkg::DIM_W + 1)'(min_y_nx) + (rsbl_pkg::DIM_W + 1)'(max_y_nx);
   end

   // Next state of pixel register, box and centre register
   always_comb begin
      pix_valid_in = pix_valid_ff;
      pix_in       = pix_ff;
      if (in_valid && in_ready) begin
         pix_valid_in = 1'b1;
         pix_in       = in_data;
      end else if (pix_leave) begin
         pix_valid_in = 1'b0;
      end

      box_min_x_in = box_min_x_ff;
      box_min_y_in = box_min_y_ff;
      box_max_x_in = box_max_x_ff;
      box_max_y_in = box_max_y_ff;
      if (pix_leave) begin
         if (pix_ff.frame_last) begin
            box_min_x_in = cfg.frame_width;
            box_min_y_in = cfg.frame_height;
            box_max_x_in = '0;
            box_max_y_in = '0;
         end else begin
            box_min_x_in = min_x_nx;
            box_min_y_in = min_y_nx;
            box_max_x_in = max_x_nx;
            box_max_y_in = max_y_nx;
         end
      end
      if (box_load.load_x) box_min_x_in = box_load.value;
      if (box_load.load_y) box_min_y_in = box_load.value;

      ctr_valid_in = ctr_valid_ff;
      ctr_in       = ctr_ff;
      if (ctr_free) begin
         ctr_valid_in    = pix_leave && pix_ff.frame_last;
         ctr_in.centre_x = sum_x[rsbl_pkg::DIM_W:1];
         ctr_in.centre_y = sum_y[rsbl_pkg::DIM_W:1];
         ctr_in.found    = (min_x_nx != cfg.frame_width || min_y_nx != cfg.frame_height) &&
                           (max_x_nx != '0 || max_y_nx != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
         ctr_valid_ff <= 1'b0;
         box_min_x_ff <= rsbl_pkg::FRAME_WIDTH_RST;
         box_min_y_ff <= rsbl_pkg::FRAME_HEIGHT_RST;
         box_max_x_ff <= '0;
         box_max_y_ff <= '0;
      end else begin
         pix_valid_ff <= pix_valid_in;
         ctr_valid_ff <= ctr_valid_in;
         box_min_x_ff <= box_min_x_in;
         box_min_y_ff <= box_min_y_in;
         box_max_x_ff <= box_max_x_in;
         box_max_y_ff <= box_max_y_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      ctr_ff <= ctr_in;
   end

   assign out_valid = ctr_valid_ff;
   assign out_data  = ctr_ff;

endmodule

`default_nettype wire

@@ hw/rtl/rsbl_scale.sv @@
// Product stage: box centre times the per-axis Q4.16 scale, truncated.
// Depends on rsbl_pkg.
`default_nettype none

module rsbl_scale (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rsbl_pkg::cfg_type     cfg,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire rsbl_pkg::centre_type  in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output rsbl_pkg::scaled_type       out_data
);

   localparam int FULL_W = rsbl_pkg::DIM_W + rsbl_pkg::SCALE_W;

   logic                 prod_valid_ff, prod_valid_in;
   rsbl_pkg::scaled_type prod_ff, prod_in;
   logic [FULL_W-1:0]    full_x, full_y;

   assign in_ready = !prod_valid_ff || out_ready;

   // Multiply and drop the fraction bits
   always_comb begin
      full_x = FULL_W'(in_data.centre_x) * FULL_W'(cfg.scale_x);
      full_y = FULL_W'(in_data.centre_y) * FULL_W'(cfg.scale_y);
      prod_valid_in = prod_valid_ff;
      prod_in       = prod_ff;
      if (in_ready) begin
         prod_valid_in    = in_valid;
         prod_in.scaled_x = full_x[FULL_W-1:rsbl_pkg::SCALE_FRAC];
         prod_in.scaled_y = full_y[FULL_W-1:rsbl_pkg::SCALE_FRAC];
         prod_in.found    = in_data.found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign out_valid = prod_valid_ff;
   assign out_data  = prod_ff;

endmodule

`default_nettype wire

@@ hw/rtl/rsbl_clamp.sv @@
// Output stage: clamp to the plate, hold the last position, result register.
// Depends on rsbl_pkg.
`default_nettype none

module rsbl_clamp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rsbl_pkg::cfg_type     cfg,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire rsbl_pkg::scaled_type  in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output rsbl_pkg::spot_type         out_data
);

   logic                         rsp_valid_ff, rsp_valid_in;
   rsbl_pkg::spot_type           rsp_ff, rsp_in;
   logic [rsbl_pkg::COORD_W-1:0] held_x_ff, held_x_in;
   logic [rsbl_pkg::COORD_W-1:0] held_y_ff, held_y_in;
   logic [rsbl_pkg::PROD_W-1:0]  pick_x, pick_y;
   logic [rsbl_pkg::COORD_W-1:0] pos_x, pos_y;

   // Upper bound first, then the lower bound, which wins on conflict
   function automatic logic [rsbl_pkg::COORD_W-1:0] clamp_axis(
      input logic [rsbl_pkg::PROD_W-1:0]   v,
      input logic [rsbl_pkg::EXTENT_W-1:0] extent,
      input logic [rsbl_pkg::MARGIN_W-1:0] margin
   );
      logic signed [rsbl_pkg::CLAMP_W-1:0] v_s, upper_s, lower_s, t_s;
      v_s     = signed'((rsbl_pkg::CLAMP_W)'(v));
      lower_s = signed'((rsbl_pkg::CLAMP_W)'(margin));
      upper_s = signed'((rsbl_pkg::CLAMP_W)'(extent)) - lower_s;
      t_s = (v_s >= upper_s) ? upper_s : v_s;
      if (t_s <= lower_s) t_s = lower_s;
      return t_s[rsbl_pkg::COORD_W-1:0];
   endfunction

   assign in_ready = !rsp_valid_ff || out_ready;

   always_comb begin
      pick_x = in_data.found ? in_data.scaled_x : rsbl_pkg::PROD_W'(held_x_ff);
      pick_y = in_data.found ? in_data.scaled_y : rsbl_pkg::PROD_W'(held_y_ff);
      pos_x  = clamp_axis(pick_x, cfg.plate_extent, cfg.edge_margin);
      pos_y  = clamp_axis(pick_y, cfg.plate_extent, cfg.edge_margin);

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      held_x_in    = held_x_ff;
      held_y_in    = held_y_ff;
      if (in_valid && in_ready) begin
         rsp_valid_in      = 1'b1;
         rsp_in.spot_x     = pos_x;
         rsp_in.spot_y     = pos_y;
         rsp_in.spot_found = in_data.found;
         held_x_in         = pos_x;
         held_y_in         = pos_y;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         held_x_ff    <= rsbl_pkg::HELD_RST;
         held_y_ff    <= rsbl_pkg::HELD_RST;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         held_x_ff    <= held_x_in;
         held_y_ff    <= held_y_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

`default_nettype wire

@@ hw/rtl/red_spot_bbox_locator_top.sv @@
// Red spot bounding-box locator: one pixel word per cycle in, one spot word per frame out.
// A frame's last pixel reaches the spot word through the pixel register, centre
// register, product register and result register.
// Throughput: one pixel per cycle; the pipeline stalls only while a spot word waits.
// Reset (synchronous, active high) loads register defaults, clears the box, sets the
// held position to 200,200 and empties every stage. Depends on rsbl_pkg and submodules.
`default_nettype none

module red_spot_bbox_locator_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire rsbl_pkg::pixel_type                  req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output rsbl_pkg::spot_type                        rsp_data,
   input  wire logic                                csr_wr_en,
   input  wire logic [rsbl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [rsbl_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   rsbl_pkg::cfg_type      cfg_ff, cfg_in;
   rsbl_pkg::box_load_type box_load;
   logic                   ctr_valid, ctr_ready;
   rsbl_pkg::centre_type   ctr_data;
   logic                   prod_valid, prod_ready;
   rsbl_pkg::scaled_type   prod_data;

   // Decode register writes
   always_comb begin
      cfg_in         = cfg_ff;
      box_load       = '0;
      box_load.value = csr_wdata[rsbl_pkg::DIM_W-1:0];
      if (csr_wr_en) begin
         unique case (rsbl_pkg::reg_index_type'(csr_index))
            rsbl_pkg::REG_FRAME_WIDTH: begin
               cfg_in.frame_width = csr_wdata[rsbl_pkg::DIM_W-1:0];
               box_load.load_x    = 1'b1;
            end
            rsbl_pkg::REG_FRAME_HEIGHT: begin
               cfg_in.frame_height = csr_wdata[rsbl_pkg::DIM_W-1:0];
               box_load.load_y     = 1'b1;
            end
            rsbl_pkg::REG_SCALE_X: begin
               cfg_in.scale_x = csr_wdata[rsbl_pkg::SCALE_W-1:0];
            end
            rsbl_pkg::REG_SCALE_Y: begin
               cfg_in.scale_y = csr_wdata[rsbl_pkg::SCALE_W-1:0];
            end
            rsbl_pkg::REG_PLATE_EXTENT: begin
               cfg_in.plate_extent = csr_wdata[rsbl_pkg::EXTENT_W-1:0];
            end
            rsbl_pkg::REG_EDGE_MARGIN: begin
               cfg_in.edge_margin = csr_wdata[rsbl_pkg::MARGIN_W-1:0];
            end
            rsbl_pkg::REG_DIFF_THRESHOLD: begin
               cfg_in.diff_threshold = csr_wdata[rsbl_pkg::CHAN_W-1:0];
            end
            rsbl_pkg::REG_CHANNEL_LIMIT: begin
               cfg_in.channel_limit = csr_wdata[rsbl_pkg::CHAN_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width    <= rsbl_pkg::FRAME_WIDTH_RST;
         cfg_ff.frame_height   <= rsbl_pkg::FRAME_HEIGHT_RST;
         cfg_ff.scale_x        <= rsbl_pkg::SCALE_RST;
         cfg_ff.scale_y        <= rsbl_pkg::SCALE_RST;
         cfg_ff.plate_extent   <= rsbl_pkg::PLATE_EXTENT_RST;
         cfg_ff.edge_margin    <= rsbl_pkg::EDGE_MARGIN_RST;
         cfg_ff.diff_threshold <= rsbl_pkg::DIFF_THRESHOLD_RST;
         cfg_ff.channel_limit  <= rsbl_pkg::CHANNEL_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pixel classification and box tracking
   rsbl_box u_box (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .box_load  (box_load),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (ctr_valid),
      .out_ready (ctr_ready),
      .out_data  (ctr_data)
   );

   // Centre scaling
   rsbl_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (ctr_valid),
      .in_ready  (ctr_ready),
      .in_data   (ctr_data),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   // Clamp, hold and result register
   rsbl_clamp u_clamp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ hw/rtl/rsbl_checker.sv @@
// Port-level checks for the red spot locator, bound to the top level.
// Depends on rsbl_pkg and red_spot_bbox_locator_top.
`default_nettype none

module rsbl_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire rsbl_pkg::spot_type    rsp_data
);

   // A stalled spot word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("spot word changed or dropped while stalled");

   // With the result side free, the pipeline always takes a pixel
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("pixel refused while result side is free");

   // Reset leaves the block empty and ready
   assert property (@(posedge clock)
      !reset && $past(reset) |-> req_ready && !rsp_valid)
      else $error("block not empty after reset");

   // A pixel word offered while the block is free is taken at once
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> req_ready)
      else $error("pixel stalled with no spot word pending");

endmodule

bind red_spot_bbox_locator_top rsbl_checker u_checker (.*);

`default_nettype wire
